@@ hdl/tick_timer_bank_with_minute_clock_unit_defines.svh @@
`ifndef TICK_TIMER_BANK_WITH_MINUTE_CLOCK_UNIT_DEFINES_SVH
`define TICK_TIMER_BANK_WITH_MINUTE_CLOCK_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk and held off during reset
`define TTB_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ttb check failed");

// next-cycle implication, clocked on clk and held off during reset
`define TTB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ttb check failed");

`endif

@@ hdl/ttb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

	localparam int TIMER_W   = 16;
	localparam int TICK_W    = 13;
	localparam int MINUTE_W  = 32;
	localparam int MASK_W    = 8;
	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 3;
	localparam int CMP_W     = 5;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [4:0] MINUTE_QUARTER_MASK = 5'h03;
	localparam logic [4:0] MINUTE_PERIOD_MASK  = 5'h1f;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic               shift;
		logic               dec;
		logic               load;
		logic [TIMER_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/ttb_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttb_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ttb_pkg::cell_ctl_t             ctl,
	input  wire logic [ttb_pkg::TIMER_W-1:0]    d,
	output logic      [ttb_pkg::TIMER_W-1:0]    q,
	output logic      [ttb_pkg::TIMER_W-1:0]    nxt
);

	always_comb begin
		nxt = d;
		if (ctl.load) begin
			nxt = ctl.value;
		end else if (ctl.dec && d != '0) begin
			nxt = d - ttb_pkg::TIMER_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ctl.shift) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ hdl/ttb_clock.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttb_clock #(
	parameter int TICKS_PER_MINUTE = 7325
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            tick,
	output logic      [ttb_pkg::TICK_W-1:0]      ticks_q,
	output logic      [ttb_pkg::MINUTE_W-1:0]    minutes_q
);

	logic [ttb_pkg::TICK_W:0]     next_tick;
	logic [ttb_pkg::MINUTE_W-1:0] next_minutes;
	logic [4:0]                   low_bits;
	logic                         roll;

	always_comb begin
		next_tick    = {1'b0, ticks_q} + (ttb_pkg::TICK_W + 1)'(1);
		roll         = next_tick >= (ttb_pkg::TICK_W + 1)'(TICKS_PER_MINUTE);
		next_minutes = minutes_q + ttb_pkg::MINUTE_W'(1);
		low_bits     = next_minutes[4:0] & ttb_pkg::MINUTE_PERIOD_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= ttb_pkg::TICK_W'(1);
			minutes_q <= '0;
		end else if (tick) begin
			if (roll) begin
				minutes_q <= next_minutes;
				// extra tick on every fourth minute, except at the 32 minute boundary
				if ((low_bits & ttb_pkg::MINUTE_QUARTER_MASK) == 5'h00 && low_bits != 5'h00) begin
					ticks_q <= '0;
				end else begin
					ticks_q <= ttb_pkg::TICK_W'(1);
				end
			end else begin
				ticks_q <= next_tick[ttb_pkg::TICK_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/tick_timer_bank_with_minute_clock_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "tick_timer_bank_with_minute_clock_unit_defines.svh"

// channel  | direction | tdata fields, lowest bit first
// s_axis   | in        | command[1:0], timer_index[4:2], load_value[20:5], zero fill to 24
// m_axis   | out       | tick_now[12:0], minutes_now[44:13], timer_now[60:45],
//          |           | expired_mask[68:61], zero fill to 72
//
// an item goes through accept, then the ring of timer cells turns once past the head,
// processing each timer in turn, then the output register loads
// on a tick command the minute clock updates at the accepting edge, the ring then walks all timers
// reset clears every timer, sets the tick counter to one and the minutes to zero
// a stalled output holds its item; the next item still turns the ring, then waits
// in flush until the output register is free

module tick_timer_bank_with_minute_clock_unit #(
	parameter int TIMER_COUNT      = 8,
	parameter int TICKS_PER_MINUTE = 7325
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // command, timer_index, load_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [71:0] m_tdata   // tick_now, minutes_now, timer_now, expired_mask
);

	localparam int SW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	ttb_pkg::state_t state_q, state_d;

	logic [SW-1:0]                  step_q;
	logic                           tick_q;
	logic                           load_q;
	logic [ttb_pkg::INDEX_W-1:0]    index_q;
	logic [ttb_pkg::TIMER_W-1:0]    value_q;
	logic [ttb_pkg::TIMER_W-1:0]    shown_q;
	logic [ttb_pkg::MASK_W-1:0]     mask_q;
	logic                           accept;
	logic                           running;
	logic                           last_step;
	logic                           out_load;
	logic                           out_free;
	logic [ttb_pkg::CMD_W-1:0]      in_command;
	logic [ttb_pkg::INDEX_W-1:0]    in_index;
	logic [ttb_pkg::TIMER_W-1:0]    in_value;
	logic [ttb_pkg::TICK_W-1:0]     ticks;
	logic [ttb_pkg::MINUTE_W-1:0]   minutes;
	logic [ttb_pkg::TIMER_W-1:0]    head_val;
	logic                           head_hit;

	logic [ttb_pkg::TIMER_W-1:0]    cell_q   [TIMER_COUNT];
	logic [ttb_pkg::TIMER_W-1:0]    cell_nxt [TIMER_COUNT];
	ttb_pkg::cell_ctl_t             cell_ctl [TIMER_COUNT];

	assign in_command = s_tdata[1:0];
	assign in_index   = s_tdata[4:2];
	assign in_value   = s_tdata[20:5];

	assign accept    = s_tvalid && s_tready;
	assign running   = state_q == ttb_pkg::ST_RUN;
	assign last_step = step_q == SW'(TIMER_COUNT - 1);
	assign out_free  = !m_tvalid || m_tready;
	assign head_hit  = ttb_pkg::CMP_W'(step_q) == ttb_pkg::CMP_W'(index_q);
	// the tail cell takes the head timer back after processing it
	assign head_val  = cell_nxt[TIMER_COUNT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ttb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ttb_pkg::ST_RUN;
				end
			end
			ttb_pkg::ST_RUN: begin
				if (last_step) begin
					state_d = ttb_pkg::ST_FLUSH;
				end
			end
			ttb_pkg::ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ttb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			tick_q <= 1'b0;
			load_q <= 1'b0;
		end else if (accept) begin
			step_q <= '0;
			tick_q <= in_command == ttb_pkg::CMD_TICK;
			load_q <= in_command == ttb_pkg::CMD_LOAD;
		end else if (running) begin
			step_q <= last_step ? '0 : step_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			index_q <= in_index;
			value_q <= in_value;
			shown_q <= '0;
			mask_q  <= '0;
		end else if (running) begin
			if (head_hit) begin
				shown_q <= head_val;
			end
			for (int b = 0; b < ttb_pkg::MASK_W; b++) begin
				if (b < TIMER_COUNT && ttb_pkg::CMP_W'(step_q) == ttb_pkg::CMP_W'(b)
						&& head_val == '0) begin
					mask_q[b] <= 1'b1;
				end
			end
		end
	end

	ttb_clock #(
		.TICKS_PER_MINUTE(TICKS_PER_MINUTE)
	) u_clock (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (accept && in_command == ttb_pkg::CMD_TICK),
		.ticks_q  (ticks),
		.minutes_q(minutes)
	);

	for (genvar k = 0; k < TIMER_COUNT; k++) begin : g_cell
		always_comb begin
			cell_ctl[k].shift = running;
			cell_ctl[k].value = value_q;
			if (k == TIMER_COUNT - 1) begin
				cell_ctl[k].dec  = tick_q;
				cell_ctl[k].load = load_q && head_hit;
			end else begin
				cell_ctl[k].dec  = 1'b0;
				cell_ctl[k].load = 1'b0;
			end
		end

		ttb_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (cell_ctl[k]),
			.d     (cell_q[(k + 1) % TIMER_COUNT]),
			.q     (cell_q[k]),
			.nxt   (cell_nxt[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {3'b000, mask_q, shown_q, minutes, ticks};
		end
	end

	`TTB_ASSERT_NEXT(a_accept_starts_ring, accept,
		state_q == ttb_pkg::ST_RUN && step_q == '0)
	`TTB_ASSERT_NEXT(a_ring_turns_once, running && last_step, state_q == ttb_pkg::ST_FLUSH)
	`TTB_ASSERT_SAME(a_out_from_flush, $rose(m_tvalid), $past(state_q == ttb_pkg::ST_FLUSH))
	`TTB_ASSERT_SAME(a_tick_in_range, 1'b1,
		{1'b0, ticks} < (ttb_pkg::TICK_W + 1)'(TICKS_PER_MINUTE))

endmodule

`default_nettype wire
